>>> hdl/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg
// shared types and fixed widths of the radial falloff mask block
// ----------------------------------------------------------------------------
package rfm_pkg;

   // squared pixel radius, worst case over the mask size range
   localparam int D2W   = 22;
   // ramp numerator and denominator before rounding
   localparam int NUMW  = 28;
   localparam int DENW  = 20;
   // divider dividend (2*num + den) and divisor (2*den)
   localparam int NW    = 30;
   localparam int DW    = 21;

   localparam logic [7:0] STRENGTH_FULL = 8'd255;
   localparam logic [7:0] STRENGTH_NONE = 8'd0;

   localparam logic CSR_HARDNESS = 1'b0;
   localparam logic CSR_RADIUS   = 1'b1;

   typedef struct packed {
      logic        op;
      logic        zero;
      logic        full;
      logic [11:0] diff;
   } rfm_side_type;

   typedef struct packed {
      logic       en;
      logic [7:0] value;
   } rfm_force_type;

endpackage

>>> hdl/radial_falloff_mask.sv
// ----------------------------------------------------------------------------
// radial_falloff_mask
// brush falloff unit: radial mask pixels and world distance linear ramp
// ----------------------------------------------------------------------------
// path: stage 1 register, square root stages, ramp register, divider stages
// throughput: one item per cycle while the result is not stalled; the square
// root and divider are fully pipelined, one root bit and one quotient bit per stage
// a stalled result freezes the whole pipeline, holding every item in place
// reset: synchronous, clears all valid bits; hardness 128, brush_radius 240
module radial_falloff_mask #(
   parameter int MASK_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   input  logic [15:0] req_distance,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_strength,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   import rfm_pkg::*;

   // root bits: 256*sqrt(d2) stays below 512*MASK_SIZE
   localparam int LOG_S = $clog2(MASK_SIZE);
   localparam int K     = LOG_S + 9;
   localparam logic [D2W-1:0] S_SQ   = D2W'(MASK_SIZE * MASK_SIZE);
   localparam logic [K-1:0]   FULL_R = K'(256 * MASK_SIZE);

   // ---------------------------------------------------------------------
   // configuration registers, always ready
   // ---------------------------------------------------------------------
   logic [7:0]  hardness_ff;
   logic [11:0] brush_radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hardness_ff     <= 8'd128;
         brush_radius_ff <= 12'd240;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HARDNESS: hardness_ff     <= csr_data[7:0];
            CSR_RADIUS:   brush_radius_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // global advance: the pipeline moves unless the result is held
   // ---------------------------------------------------------------------
   logic advance;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // stage 1: squared pixel radius and distance mode compares
   // ---------------------------------------------------------------------
   logic signed [11:0] dx_val;
   logic signed [11:0] dy_val;
   logic signed [23:0] dx_sq;
   logic signed [23:0] dy_sq;
   logic [D2W-1:0]     d2_in;
   logic               gt_in;
   logic               full_d_in;
   logic [11:0]        diff_in;

   // dx = 2*column - S, dy = 2*row - S
   assign dx_val = $signed({3'b000, req_column, 1'b0}) - $signed(12'(MASK_SIZE));
   assign dy_val = $signed({3'b000, req_row, 1'b0}) - $signed(12'(MASK_SIZE));
   assign dx_sq  = dx_val * dx_val;
   assign dy_sq  = dy_val * dy_val;
   assign d2_in  = D2W'(dx_sq) + D2W'(dy_sq);

   // distance beyond radius, and inside the hardness radius
   assign gt_in     = req_distance > {4'b0000, brush_radius_ff};
   assign full_d_in = {req_distance, 8'b0} < 24'(20'(hardness_ff) * 20'(brush_radius_ff));
   assign diff_in   = brush_radius_ff - req_distance[11:0];

   logic           s1_valid_ff;
   logic           s1_op_ff;
   logic [D2W-1:0] s1_d2_ff;
   logic           s1_gt_ff;
   logic           s1_full_d_ff;
   logic [11:0]    s1_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff     <= req_operation;
         s1_d2_ff     <= d2_in;
         s1_gt_ff     <= gt_in;
         s1_full_d_ff <= full_d_in;
         s1_diff_ff   <= diff_in;
      end
   end

   // ---------------------------------------------------------------------
   // square root of d2 * 65536; distance items ride along unchanged
   // ---------------------------------------------------------------------
   rfm_side_type   sq_side_in;
   logic [2*K-1:0] sq_value_in;
   logic           sq_valid;
   logic [K-1:0]   sq_root;
   rfm_side_type   sq_side;

   always_comb begin
      sq_side_in.op   = s1_op_ff;
      sq_side_in.zero = s1_op_ff ? s1_gt_ff : (s1_d2_ff > S_SQ);
      sq_side_in.full = s1_full_d_ff;
      sq_side_in.diff = s1_diff_ff;
   end

   // beyond radius 1 the root is never used, so high d2 bits can drop
   assign sq_value_in = {s1_d2_ff[2*K-17:0], 16'b0};

   rfm_sqrt_pipe #(
      .K (K)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s1_valid_ff),
      .in_value  (sq_value_in),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------------------------------------------------------------
   // ramp numerator, denominator and the forced cases
   // ---------------------------------------------------------------------
   logic [K-1:0]    hs_val;
   logic [K-1:0]    root_c;
   logic [K-1:0]    x_val;
   logic [8:0]      inv_h;
   logic [NUMW-1:0] num_in;
   logic [DENW-1:0] den_in;
   rfm_force_type   force_in;

   // r < h*S is the same as d2*65536 < (h*S)^2 since h*S is whole
   assign hs_val = K'(hardness_ff) * K'(MASK_SIZE);
   assign root_c = (sq_root > FULL_R) ? FULL_R : sq_root;
   assign x_val  = FULL_R - root_c;
   assign inv_h  = 9'd256 - 9'(hardness_ff);

   always_comb begin
      force_in.en    = 1'b0;
      force_in.value = STRENGTH_FULL;
      if (sq_side.op) begin
         // 65280 * (R - d) against R * (256 - h)
         num_in = NUMW'({sq_side.diff, 16'b0}) - NUMW'({sq_side.diff, 8'b0});
         den_in = DENW'(brush_radius_ff) * DENW'(inv_h);
         if (sq_side.zero) begin
            force_in.en    = 1'b1;
            force_in.value = STRENGTH_NONE;
         end else if (sq_side.full || brush_radius_ff == 12'd0) begin
            // inside hardness, or a zero-width ramp
            force_in.en = 1'b1;
         end
      end else begin
         // 255 * (256*S - r) against S * (256 - h)
         num_in = NUMW'({x_val, 8'b0}) - NUMW'(x_val);
         den_in = DENW'(MASK_SIZE) * DENW'(inv_h);
         if (sq_side.zero) begin
            force_in.en    = 1'b1;
            force_in.value = STRENGTH_NONE;
         end else if (sq_root < hs_val) begin
            force_in.en = 1'b1;
         end
      end
   end

   logic            p_valid_ff;
   logic [NUMW-1:0] p_num_ff;
   logic [DENW-1:0] p_den_ff;
   rfm_force_type   p_force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_num_ff   <= num_in;
         p_den_ff   <= den_in;
         p_force_ff <= force_in;
      end
   end

   // ---------------------------------------------------------------------
   // rounding divide; its last stage is the output register
   // ---------------------------------------------------------------------
   rfm_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (p_valid_ff),
      .in_num    (p_num_ff),
      .in_den    (p_den_ff),
      .in_force  (p_force_ff),
      .out_valid (rsp_valid),
      .out_value (rsp_strength)
   );

endmodule

>>> hdl/rfm_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rfm_sqrt_pipe
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rfm_sqrt_pipe #(
   parameter int K = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [2*K-1:0]        in_value,
   input  rfm_pkg::rfm_side_type in_side,
   output logic                  out_valid,
   output logic [K-1:0]          out_root,
   output rfm_pkg::rfm_side_type out_side
);
   import rfm_pkg::*;

   localparam int RW = K + 3;

   logic [K-1:0]   valid_ff;
   logic [RW-1:0]  rem_ff  [K];
   logic [K-1:0]   res_ff  [K];
   logic [2*K-1:0] val_ff  [K];
   rfm_side_type   side_ff [K];

   for (genvar j = 0; j < K; j++) begin : g_stage
      logic           src_valid;
      logic [RW-1:0]  src_rem;
      logic [K-1:0]   src_res;
      logic [2*K-1:0] src_val;
      rfm_side_type   src_side;
      logic [RW-1:0]  rem_trial;
      logic [RW-1:0]  trial;
      logic [RW-1:0]  rem_in;
      logic [K-1:0]   res_in;

      if (j == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_res   = '0;
         assign src_val   = in_value;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[j-1];
         assign src_rem   = rem_ff[j-1];
         assign src_res   = res_ff[j-1];
         assign src_val   = val_ff[j-1];
         assign src_side  = side_ff[j-1];
      end

      // bring down the next bit pair and try 4*res + 1
      assign rem_trial = {src_rem[RW-3:0], src_val[2*K-1:2*K-2]};
      assign trial     = {1'b0, src_res, 2'b01};

      always_comb begin
         if (rem_trial >= trial) begin
            rem_in = rem_trial - trial;
            res_in = {src_res[K-2:0], 1'b1};
         end else begin
            rem_in = rem_trial;
            res_in = {src_res[K-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= rem_in;
            res_ff[j]  <= res_in;
            val_ff[j]  <= {src_val[2*K-3:0], 2'b00};
            side_ff[j] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[K-1];
   assign out_root  = res_ff[K-1];
   assign out_side  = side_ff[K-1];

endmodule

>>> hdl/rfm_div_pipe.sv
// ----------------------------------------------------------------------------
// rfm_div_pipe
// pipelined rounding divider, 8-bit quotient clamped to full strength
// ----------------------------------------------------------------------------
module rfm_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [rfm_pkg::NUMW-1:0]  in_num,
   input  logic [rfm_pkg::DENW-1:0]  in_den,
   input  rfm_pkg::rfm_force_type    in_force,
   output logic                      out_valid,
   output logic [7:0]                out_value
);
   import rfm_pkg::*;

   localparam int QS = 8;

   logic [NW-1:0] n_val;
   logic [DW-1:0] dv_val;
   logic          over_val;

   // rounding: floor((2*num + den) / (2*den))
   assign n_val    = {1'b0, in_num, 1'b0} + NW'(in_den);
   assign dv_val   = {in_den, 1'b0};
   assign over_val = n_val >= (NW'(dv_val) << QS);

   logic          valid0_ff;
   logic [NW-1:0] rem0_ff;
   logic [DW-1:0] dv0_ff;
   logic          over0_ff;
   rfm_force_type force0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (enable) begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem0_ff   <= n_val;
         dv0_ff    <= dv_val;
         over0_ff  <= over_val;
         force0_ff <= in_force;
      end
   end

   logic [QS-1:0] valid_ff;
   logic [NW-1:0] rem_ff   [QS];
   logic [DW-1:0] dv_ff    [QS];
   logic [QS-1:0] q_ff     [QS];
   logic          over_ff  [QS];
   rfm_force_type force_ff [QS];

   for (genvar i = 0; i < QS; i++) begin : g_bit
      localparam int B = QS - 1 - i;
      logic          src_valid;
      logic [NW-1:0] src_rem;
      logic [DW-1:0] src_dv;
      logic [QS-1:0] src_q;
      logic          src_over;
      rfm_force_type src_force;
      logic [NW-1:0] shifted;
      logic [NW-1:0] rem_in;
      logic [QS-1:0] q_in;

      if (i == 0) begin : g_first
         assign src_valid = valid0_ff;
         assign src_rem   = rem0_ff;
         assign src_dv    = dv0_ff;
         assign src_q     = '0;
         assign src_over  = over0_ff;
         assign src_force = force0_ff;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_dv    = dv_ff[i-1];
         assign src_q     = q_ff[i-1];
         assign src_over  = over_ff[i-1];
         assign src_force = force_ff[i-1];
      end

      assign shifted = NW'(src_dv) << B;

      always_comb begin
         rem_in = src_rem;
         q_in   = src_q;
         if (src_rem >= shifted) begin
            rem_in  = src_rem - shifted;
            q_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]   <= rem_in;
            dv_ff[i]    <= src_dv;
            q_ff[i]     <= q_in;
            over_ff[i]  <= src_over;
            force_ff[i] <= src_force;
         end
      end
   end

   assign out_valid = valid_ff[QS-1];

   always_comb begin
      if (force_ff[QS-1].en) begin
         out_value = force_ff[QS-1].value;
      end else if (over_ff[QS-1]) begin
         out_value = STRENGTH_FULL;
      end else begin
         out_value = q_ff[QS-1];
      end
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the radial falloff mask against a cycle-free predictor of the ramp
// ----------------------------------------------------------------------------
module tb_top;
   import rfm_pkg::*;

   localparam int SIZE      = 256;
   localparam int LATENCY   = 28;
   localparam int MAX_CYCLE = 400000;
   localparam logic OP_MASK = 1'b0;
   localparam logic OP_DIST = 1'b1;

   typedef struct packed {
      logic        op;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [15:0] world_dist;
   } brush_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = 1'b0;
   logic [7:0]  req_column = '0;
   logic [7:0]  req_row = '0;
   logic [15:0] req_distance = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_strength;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [11:0] csr_data = '0;

   radial_falloff_mask #(.MASK_SIZE(SIZE)) dut (.*);

   // predictor copy of the two registers
   logic [7:0]  hard_q = 8'd128;
   logic [11:0] radius_q = 12'd240;

   brush_item_t  pending_items[$];
   logic [7:0]   strength_due[$];
   int           failures = 0;
   int           cycle = 0;
   logic         sender_paused = 1'b0;

   initial forever #1 clock = ~clock;

   // bit-serial integer root
   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] ramp_round(longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (2 * num + den) / (2 * den);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [7:0] predict_strength(brush_item_t it);
      longint signed   dx, dy;
      longint unsigned d2, hs, r, h, rad, d, den;
      h = 64'(hard_q);
      rad = 64'(radius_q);
      if (it.op == OP_MASK) begin
         dx = 2 * longint'(it.col) - SIZE;
         dy = 2 * longint'(it.row) - SIZE;
         d2 = dx * dx + dy * dy;
         hs = h * SIZE;
         if (d2 > SIZE * SIZE) return STRENGTH_NONE;
         if (d2 * 65536 < hs * hs) return STRENGTH_FULL;
         r = int_root(d2 * 65536);
         if (r > 256 * SIZE) r = 256 * SIZE;
         return ramp_round(255 * (256 * SIZE - r), SIZE * (256 - h));
      end
      d = 64'(it.world_dist);
      if (d > rad) return STRENGTH_NONE;
      if (d * 256 < h * rad) return STRENGTH_FULL;
      den = rad * (256 - h);
      // zero-width ramp
      if (den == 0) return STRENGTH_FULL;
      return ramp_round(255 * 256 * (rad - d), den);
   endfunction

   function automatic brush_item_t rand_item();
      brush_item_t it;
      it.op = 1'($urandom_range(0, 1));
      it.col = 8'($urandom);
      it.row = 8'($urandom);
      case ($urandom_range(0, 3))
         0: it.world_dist = 16'($urandom);
         1: it.world_dist = 16'($urandom_range(0, 4095));
         default: it.world_dist = 16'($urandom_range(0, radius_q + 16));
      endcase
      return it;
   endfunction

   function automatic brush_item_t make_item(logic op, int c, int r, int d);
      brush_item_t it;
      it.op = op;
      it.col = 8'(c);
      it.row = 8'(r);
      it.world_dist = 16'(d);
      return it;
   endfunction

   // ------------------------------------------------------------------
   // driver: one item from the pending queue, random gap between items
   // ------------------------------------------------------------------
   int gap_left = 0;
   always @(posedge clock) begin
      int gap_draw;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // item taken: predict with the registers in force now
            strength_due.push_back(predict_strength(pending_items.pop_front()));
            gap_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            gap_left <= gap_draw;
            if (pending_items.size() > 0 && gap_draw == 0 && !sender_paused) begin
               req_valid <= 1'b1;
               {req_operation, req_column, req_row, req_distance} <= pending_items[0];
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0 && !sender_paused) begin
               req_valid <= 1'b1;
               {req_operation, req_column, req_row, req_distance} <= pending_items[0];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: compare each result with the oldest prediction
   // ------------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (strength_due.size() == 0) begin
               $display("%0t unexpected item: strength %0d", $time, rsp_strength);
               failures <= failures + 1;
            end else if (strength_due[0] !== rsp_strength) begin
               $display("%0t strength mismatch: expected %0d actual %0d",
                        $time, strength_due[0], rsp_strength);
               failures <= failures + 1;
               void'(strength_due.pop_front());
            end else begin
               void'(strength_due.pop_front());
            end
         end
         // stall stretches drawn per item, with quiet phases in between
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall && $urandom_range(0, 2) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
      if (cycle >= MAX_CYCLE) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(logic idx, logic [11:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_HARDNESS) hard_q = val[7:0];
      else radius_q = val;
   endtask

   // wait for the block to drain before touching the registers
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || strength_due.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, centre, ramp edges, beyond mask, distance extremes
      pending_items.push_back(make_item(OP_MASK, 128, 128, 16'hFFFF));
      pending_items.push_back(make_item(OP_MASK, 0, 0, 0));
      pending_items.push_back(make_item(OP_MASK, 255, 255, 0));
      pending_items.push_back(make_item(OP_MASK, 0, 128, 0));
      pending_items.push_back(make_item(OP_MASK, 128, 0, 0));
      pending_items.push_back(make_item(OP_MASK, 255, 128, 0));
      pending_items.push_back(make_item(OP_MASK, 192, 128, 0));
      pending_items.push_back(make_item(OP_MASK, 200, 170, 0));
      pending_items.push_back(make_item(OP_DIST, 255, 255, 0));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 120));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 180));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 240));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 241));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 16'hFFFF));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 16'h8000));
      drain();

      // zero-width ramp with a zero radius
      write_reg(CSR_RADIUS, 12'd0);
      pending_items.push_back(make_item(OP_DIST, 0, 0, 0));
      pending_items.push_back(make_item(OP_DIST, 0, 0, 1));
      drain();

      // random phases over varied settings, extremes first
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_reg(CSR_HARDNESS, 12'd0); write_reg(CSR_RADIUS, 12'd4095); end
            1: begin write_reg(CSR_HARDNESS, 12'd255); write_reg(CSR_RADIUS, 12'd1); end
            2: begin write_reg(CSR_HARDNESS, 12'd255); write_reg(CSR_RADIUS, 12'd4095); end
            3: begin write_reg(CSR_HARDNESS, 12'd0); write_reg(CSR_RADIUS, 12'd0); end
            default: begin
               write_reg(CSR_HARDNESS, 12'($urandom_range(0, 255)));
               write_reg(CSR_RADIUS, 12'($urandom_range(0, 4095)));
            end
         endcase
         repeat (100) pending_items.push_back(rand_item());
         // sender holds off mid-phase until every result is back
         if (phase == 5) begin
            while (pending_items.size() > 50) @(posedge clock);
            sender_paused = 1'b1;
            while (req_valid || strength_due.size() > 0) @(posedge clock);
            sender_paused = 1'b0;
         end
         drain();
      end

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
